>>> sv/dequ_pkg.sv
// Shared types and constants for the double-ended queue unit.
package dequ_pkg;

    localparam int DEPTH_DEF   = 64;
    localparam int DATA_W      = 32;
    localparam int FUNC_W      = 3;
    localparam int STATUS_W    = 2;
    localparam int IN_TDATA_W  = 40;
    localparam int OUT_TDATA_W = 40;
    localparam int IN_PAD_W    = IN_TDATA_W - FUNC_W - DATA_W;
    localparam int OUT_PAD_W   = OUT_TDATA_W - STATUS_W - DATA_W;

    // Operation codes carried in the input item
    typedef enum logic [FUNC_W-1:0] {
        FUNC_PUSH_FRONT = 3'd0,
        FUNC_PUSH_BACK  = 3'd1,
        FUNC_POP_FRONT  = 3'd2,
        FUNC_POP_BACK   = 3'd3,
        FUNC_DUMP_FWD   = 3'd4,
        FUNC_DUMP_BWD   = 3'd5
    } func_t;

    // Result status codes
    typedef enum logic [STATUS_W-1:0] {
        STAT_OK    = 2'd0,
        STAT_EMPTY = 2'd1,
        STAT_FULL  = 2'd2
    } status_t;

    // Back-end sequencer states
    typedef enum logic {
        BK_IDLE = 1'b0,
        BK_OUT  = 1'b1
    } bk_state_t;

    // Command handed from the front end to the back end
    typedef struct packed {
        func_t                    func;
        logic signed [DATA_W-1:0] value;
    } cmd_t;

endpackage

>>> sv/dequ_ram.sv
// Generic single-write, single-read RAM with registered read data.
module dequ_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Read port, data held while not enabled
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

>>> sv/dequ_front.sv
// Front end: accepts items, drops unknown operations, queues commands.
module dequ_front
    import dequ_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic [IN_TDATA_W-1:0] in_data,
    output logic                  cmd_valid,
    input  logic                  cmd_ready,
    output cmd_t                  cmd
);

    cmd_t       slot_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;
    logic       known;
    logic       push;
    logic       pop;
    cmd_t       in_cmd;

    // Classify the incoming item
    always_comb
    begin
        in_cmd.func  = func_t'(in_data[FUNC_W-1:0]);
        in_cmd.value = in_data[FUNC_W +: DATA_W];
        known        = in_data[FUNC_W-1:0] inside {FUNC_PUSH_FRONT, FUNC_PUSH_BACK,
                                                   FUNC_POP_FRONT, FUNC_POP_BACK,
                                                   FUNC_DUMP_FWD, FUNC_DUMP_BWD};
    end

    assign in_ready  = (count_reg != 2'd2);
    assign cmd_valid = (count_reg != 2'd0);
    assign cmd       = slot_reg[rd_ptr_reg];
    assign push      = in_valid && in_ready && known;
    assign pop       = cmd_valid && cmd_ready;

    // Pointer and fill count update
    always_comb
    begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        case ({push, pop})
            2'b10:   count_next = count_reg + 2'd1;
            2'b01:   count_next = count_reg - 2'd1;
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Command slots, payload only
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= in_cmd;
        end
    end

endmodule

>>> sv/dequ_back.sv
// Back end: executes queued commands against the ring store, drives results.
module dequ_back
    import dequ_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEF
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     cmd_valid,
    output logic                     cmd_ready,
    input  cmd_t                     cmd,
    output logic                     out_valid,
    input  logic                     out_ready,
    output status_t                  out_status,
    output logic signed [DATA_W-1:0] out_item,
    output logic                     out_last
);

    localparam int IDX_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    bk_state_t                state_reg, state_next;
    logic [IDX_W-1:0]         front_reg, front_next;
    logic [IDX_W-1:0]         back_reg, back_next;
    logic [CNT_W-1:0]         occ_reg, occ_next;
    logic [IDX_W-1:0]         pos_reg, pos_next;
    logic [CNT_W-1:0]         cnt_reg, cnt_next;
    logic                     fwd_reg, fwd_next;
    logic                     out_valid_reg, out_valid_next;
    status_t                  out_status_reg, status_new;
    logic signed [DATA_W-1:0] out_item_reg, item_new;
    logic                     out_last_reg, last_new;

    logic                     out_free;
    logic                     load_out;
    logic                     go_out;
    logic                     done;
    logic                     empty;
    logic                     full;
    logic                     wr_en;
    logic [IDX_W-1:0]         wr_addr;
    logic                     rd_en;
    logic [IDX_W-1:0]         rd_addr;
    logic [IDX_W-1:0]         start;
    logic [DATA_W-1:0]        rd_data;

    function automatic logic [IDX_W-1:0] idx_inc(input logic [IDX_W-1:0] i);
        return (i == IDX_W'(DEPTH - 1)) ? '0 : i + IDX_W'(1);
    endfunction

    function automatic logic [IDX_W-1:0] idx_dec(input logic [IDX_W-1:0] i);
        return (i == '0) ? IDX_W'(DEPTH - 1) : i - IDX_W'(1);
    endfunction

    dequ_ram #(
        .WIDTH (DATA_W),
        .DEPTH (DEPTH)
    ) u_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (cmd.value),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    assign out_free = !out_valid_reg || out_ready;
    assign empty    = (occ_reg == '0);
    assign full     = (occ_reg == CNT_W'(DEPTH));

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            BK_IDLE:
            begin
                if (go_out)
                begin
                    state_next = BK_OUT;
                end
            end
            BK_OUT:
            begin
                if (done)
                begin
                    state_next = BK_IDLE;
                end
            end
            default: state_next = BK_IDLE;
        endcase
    end

    // Datapath control and register updates
    always_comb
    begin
        cmd_ready  = 1'b0;
        load_out   = 1'b0;
        go_out     = 1'b0;
        done       = 1'b0;
        wr_en      = 1'b0;
        wr_addr    = front_reg;
        rd_en      = 1'b0;
        rd_addr    = pos_reg;
        start      = front_reg;
        status_new = STAT_OK;
        item_new   = '0;
        last_new   = 1'b1;
        front_next = front_reg;
        back_next  = back_reg;
        occ_next   = occ_reg;
        pos_next   = pos_reg;
        cnt_next   = cnt_reg;
        fwd_next   = fwd_reg;
        case (state_reg)
            BK_IDLE:
            begin
                if (cmd_valid)
                begin
                    case (cmd.func)
                        FUNC_PUSH_FRONT, FUNC_PUSH_BACK:
                        begin
                            if (out_free)
                            begin
                                cmd_ready = 1'b1;
                                load_out  = 1'b1;
                                if (full)
                                begin
                                    status_new = STAT_FULL;
                                end
                                else
                                begin
                                    wr_en    = 1'b1;
                                    occ_next = occ_reg + CNT_W'(1);
                                    if (empty)
                                    begin
                                        wr_addr   = front_reg;
                                        back_next = front_reg;
                                    end
                                    else if (cmd.func == FUNC_PUSH_FRONT)
                                    begin
                                        wr_addr    = idx_dec(front_reg);
                                        front_next = idx_dec(front_reg);
                                    end
                                    else
                                    begin
                                        wr_addr   = idx_inc(back_reg);
                                        back_next = idx_inc(back_reg);
                                    end
                                end
                            end
                        end
                        FUNC_POP_FRONT, FUNC_POP_BACK, FUNC_DUMP_FWD, FUNC_DUMP_BWD:
                        begin
                            if (empty)
                            begin
                                if (out_free)
                                begin
                                    cmd_ready  = 1'b1;
                                    load_out   = 1'b1;
                                    status_new = STAT_EMPTY;
                                end
                            end
                            else
                            begin
                                cmd_ready = 1'b1;
                                go_out    = 1'b1;
                                rd_en     = 1'b1;
                                fwd_next  = (cmd.func == FUNC_POP_FRONT) ||
                                            (cmd.func == FUNC_DUMP_FWD);
                                start     = fwd_next ? front_reg : back_reg;
                                rd_addr   = start;
                                pos_next  = fwd_next ? idx_inc(start) : idx_dec(start);
                                if ((cmd.func == FUNC_POP_FRONT) || (cmd.func == FUNC_POP_BACK))
                                begin
                                    cnt_next = CNT_W'(1);
                                    occ_next = occ_reg - CNT_W'(1);
                                    if (occ_reg != CNT_W'(1))
                                    begin
                                        if (cmd.func == FUNC_POP_FRONT)
                                        begin
                                            front_next = idx_inc(front_reg);
                                        end
                                        else
                                        begin
                                            back_next = idx_dec(back_reg);
                                        end
                                    end
                                end
                                else
                                begin
                                    cnt_next = occ_reg;
                                end
                            end
                        end
                        default:
                        begin
                            cmd_ready = 1'b1;
                        end
                    endcase
                end
            end
            BK_OUT:
            begin
                // One stored value per free output slot
                if (out_free)
                begin
                    load_out = 1'b1;
                    item_new = rd_data;
                    last_new = (cnt_reg == CNT_W'(1));
                    cnt_next = cnt_reg - CNT_W'(1);
                    if (cnt_reg == CNT_W'(1))
                    begin
                        done = 1'b1;
                    end
                    else
                    begin
                        rd_en    = 1'b1;
                        rd_addr  = pos_reg;
                        pos_next = fwd_reg ? idx_inc(pos_reg) : idx_dec(pos_reg);
                    end
                end
            end
            default:
            begin
                done = 1'b1;
            end
        endcase
        out_valid_next = load_out || (out_valid_reg && !out_ready);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= BK_IDLE;
            front_reg     <= '0;
            back_reg      <= '0;
            occ_reg       <= '0;
            pos_reg       <= '0;
            cnt_reg       <= '0;
            fwd_reg       <= 1'b1;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            front_reg     <= front_next;
            back_reg      <= back_next;
            occ_reg       <= occ_next;
            pos_reg       <= pos_next;
            cnt_reg       <= cnt_next;
            fwd_reg       <= fwd_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Result payload
    always_ff @(posedge clk)
    begin
        if (load_out)
        begin
            out_status_reg <= status_new;
            out_item_reg   <= item_new;
            out_last_reg   <= last_new;
        end
    end

    assign out_valid  = out_valid_reg;
    assign out_status = out_status_reg;
    assign out_item   = out_item_reg;
    assign out_last   = out_last_reg;

    // Occupancy never exceeds the ring size
    a_occ_bound: assert property (@(posedge clk) disable iff (!rst_n)
        occ_reg <= CNT_W'(DEPTH))
        else $error("occupancy above depth");

    // An empty queue has both ends on the same slot
    a_empty_ends: assert property (@(posedge clk) disable iff (!rst_n)
        (occ_reg == '0) |-> (front_reg == back_reg))
        else $error("ends differ while empty");

    // While emitting, results remain to be sent
    a_out_count: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == BK_OUT) |-> (cnt_reg != '0))
        else $error("emit state with zero count");

    // No new command is taken while values are being emitted
    a_no_cmd_in_out: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == BK_OUT) |-> !cmd_ready)
        else $error("command taken during emit");

endmodule

>>> sv/double_ended_queue_unit.sv
// Top level of the double-ended queue unit: front end, command queue, back end.
//
//  Channel   Dir  Handshake                      Payload
//  s_axis    in   s_axis_tvalid / s_axis_tready  tdata: func[2:0], value[34:3]
//  m_axis    out  m_axis_tvalid / m_axis_tready  tdata: status[1:0], item[33:2]; tlast
//
//  Push and errors are answered in the back end's idle state. Pop: ring store
//  read in the idle state, then the result. Dump: first read in the idle state,
//  then one result per cycle while the output is free, limited by the single
//  registered read port of the ring store. A two-entry command queue lets the
//  front end accept while the back end works. Reset empties the queue; the ring
//  store needs no clearing. A stalled output holds its result and stops the
//  back end; items with an unknown operation are accepted and dropped.
module double_ended_queue_unit
    import dequ_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEF
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    input  logic [IN_TDATA_W-1:0]  s_axis_tdata,   // func[2:0], value[34:3], zero pad
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    output logic [OUT_TDATA_W-1:0] m_axis_tdata,   // status[1:0], item[33:2], zero pad
    output logic                   m_axis_tlast
);

    logic                     cmd_valid;
    logic                     cmd_ready;
    cmd_t                     cmd;
    status_t                  res_status;
    logic signed [DATA_W-1:0] res_item;

    dequ_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .in_data   (s_axis_tdata),
        .cmd_valid (cmd_valid),
        .cmd_ready (cmd_ready),
        .cmd       (cmd)
    );

    dequ_back #(
        .DEPTH (DEPTH)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd_valid  (cmd_valid),
        .cmd_ready  (cmd_ready),
        .cmd        (cmd),
        .out_valid  (m_axis_tvalid),
        .out_ready  (m_axis_tready),
        .out_status (res_status),
        .out_item   (res_item),
        .out_last   (m_axis_tlast)
    );

    // Pack result fields, lowest first
    assign m_axis_tdata = {{OUT_PAD_W{1'b0}}, res_item, res_status};

endmodule

>>> tb/sv/deque_checker.sv
// Checker for the double-ended queue unit: tracks the queue contents and compares every result.
`timescale 1ns / 1ps

module deque_checker
    import dequ_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   s_axis_tvalid,
    input  logic                   s_axis_tready,
    input  logic [IN_TDATA_W-1:0]  s_axis_tdata,   // func[2:0], value[34:3], zero pad
    input  logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    input  logic [OUT_TDATA_W-1:0] m_axis_tdata,   // status[1:0], item[33:2], zero pad
    input  logic                   m_axis_tlast,
    output int                     fail_count,
    output int                     pending
);

    typedef struct {
        logic [STATUS_W-1:0] status;
        logic [DATA_W-1:0]   item;
        logic                last;
    } deque_result_t;

    // Shadow copy of the ring store and its pointers
    logic [DATA_W-1:0] ring [DEPTH_DEF];
    int                head_slot;
    int                tail_slot;
    int                fill;

    deque_result_t     want_q[$];
    deque_result_t     want;

    function automatic int next_slot(input int i);
        return (i + 1 == DEPTH_DEF) ? 0 : i + 1;
    endfunction

    function automatic int prev_slot(input int i);
        return (i == 0) ? DEPTH_DEF - 1 : i - 1;
    endfunction

    task automatic add_result(input logic [STATUS_W-1:0] status,
                              input logic [DATA_W-1:0] item, input logic last);
        deque_result_t r;
        r.status = status;
        r.item   = item;
        r.last   = last;
        want_q.push_back(r);
    endtask

    // Apply one accepted operation to the shadow queue and queue up its results
    task automatic apply_op(input logic [FUNC_W-1:0] op, input logic [DATA_W-1:0] val);
        int pos;
        logic [DATA_W-1:0] got;
        case (op)
            FUNC_PUSH_FRONT, FUNC_PUSH_BACK:
            begin
                if (fill >= DEPTH_DEF)
                begin
                    add_result(STAT_FULL, '0, 1'b1);
                end
                else
                begin
                    if (fill == 0)
                    begin
                        tail_slot = head_slot;
                        pos = head_slot;
                    end
                    else if (op == FUNC_PUSH_FRONT)
                    begin
                        head_slot = prev_slot(head_slot);
                        pos = head_slot;
                    end
                    else
                    begin
                        tail_slot = next_slot(tail_slot);
                        pos = tail_slot;
                    end
                    ring[pos] = val;
                    fill++;
                    add_result(STAT_OK, '0, 1'b1);
                end
            end
            FUNC_POP_FRONT, FUNC_POP_BACK:
            begin
                if (fill == 0)
                begin
                    add_result(STAT_EMPTY, '0, 1'b1);
                end
                else
                begin
                    if (op == FUNC_POP_FRONT)
                    begin
                        got = ring[head_slot];
                        if (fill > 1)
                            head_slot = next_slot(head_slot);
                    end
                    else
                    begin
                        got = ring[tail_slot];
                        if (fill > 1)
                            tail_slot = prev_slot(tail_slot);
                    end
                    fill--;
                    add_result(STAT_OK, got, 1'b1);
                end
            end
            FUNC_DUMP_FWD, FUNC_DUMP_BWD:
            begin
                if (fill == 0)
                begin
                    add_result(STAT_EMPTY, '0, 1'b1);
                end
                else
                begin
                    pos = (op == FUNC_DUMP_FWD) ? head_slot : tail_slot;
                    for (int n = 0; n < fill; n++)
                    begin
                        add_result(STAT_OK, ring[pos], (n + 1 == fill));
                        pos = (op == FUNC_DUMP_FWD) ? next_slot(pos) : prev_slot(pos);
                    end
                end
            end
            default:
            begin
                // reserved codes are dropped without a result
            end
        endcase
    endtask

    // Compare results first: a result can never belong to an item taken on the same edge
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_slot  = 0;
            tail_slot  = 0;
            fill       = 0;
            fail_count = 0;
            pending    = 0;
            want_q.delete();
        end
        else
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                if (want_q.size() == 0)
                begin
                    if (fail_count < 10)
                        $display("%0t: unexpected result status %0d item %h last %b", $realtime,
                                 m_axis_tdata[STATUS_W-1:0],
                                 m_axis_tdata[STATUS_W +: DATA_W], m_axis_tlast);
                    fail_count++;
                end
                else
                begin
                    want = want_q.pop_front();
                    if (m_axis_tdata[STATUS_W-1:0] !== want.status ||
                        m_axis_tdata[STATUS_W +: DATA_W] !== want.item ||
                        m_axis_tlast !== want.last)
                    begin
                        if (fail_count < 10)
                            $display("%0t: mismatch: expected status %0d item %h last %b, got status %0d item %h last %b",
                                     $realtime, want.status, want.item, want.last,
                                     m_axis_tdata[STATUS_W-1:0],
                                     m_axis_tdata[STATUS_W +: DATA_W], m_axis_tlast);
                        fail_count++;
                    end
                end
            end
            if (s_axis_tvalid && s_axis_tready)
                apply_op(s_axis_tdata[FUNC_W-1:0], s_axis_tdata[FUNC_W +: DATA_W]);
            pending = want_q.size();
        end
    end

endmodule

>>> tb/sv/tb.sv
// Testbench top for the double-ended queue unit: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps

module tb;
    import dequ_pkg::*;

    // Codes outside the defined operations; the block must drop them
    localparam logic [FUNC_W-1:0] FUNC_RSVD_A = 3'd6;
    localparam logic [FUNC_W-1:0] FUNC_RSVD_B = 3'd7;

    logic                   clk           = 1'b0;
    logic                   rst_n         = 1'b0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    logic [IN_TDATA_W-1:0]  s_axis_tdata  = '0;   // func[2:0], value[34:3], zero pad
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_axis_tdata;         // status[1:0], item[33:2], zero pad
    logic                   m_axis_tlast;

    int fail_count;
    int pending;
    int send_idle_pct = 29;
    int recv_idle_pct = 69;
    int ops_sent      = 0;

    always #1 clk = ~clk;

    double_ended_queue_unit dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    deque_checker chk (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .fail_count    (fail_count),
        .pending       (pending)
    );

    // Receiver backpressure
    always @(negedge clk)
        m_axis_tready <= ($urandom_range(0, 99) >= recv_idle_pct);

    // Offer one item, with random gaps in front; returns at the negedge after acceptance
    task automatic send_item(input logic [FUNC_W-1:0] func, input logic [DATA_W-1:0] value);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {{IN_PAD_W{1'b0}}, value, func};
        do
            @(posedge clk);
        while (!s_axis_tready);
        @(negedge clk);
        if (func <= FUNC_DUMP_BWD)
            ops_sent++;
    endtask

    function automatic logic [FUNC_W-1:0] any_push();
        return $urandom_range(0, 1) ? FUNC_PUSH_BACK : FUNC_PUSH_FRONT;
    endfunction

    function automatic logic [FUNC_W-1:0] any_pop();
        return $urandom_range(0, 1) ? FUNC_POP_BACK : FUNC_POP_FRONT;
    endfunction

    // Bursts of pushes and pops with dumps and stray codes mixed in
    task automatic random_ops(input int n);
        int target;
        int len;
        target = ops_sent + n;
        while (ops_sent < target)
        begin
            case ($urandom_range(0, 9))
                0, 1, 2, 3:
                begin
                    len = $urandom_range(1, 12);
                    repeat (len) send_item(any_push(), $urandom());
                end
                4, 5, 6:
                begin
                    len = $urandom_range(1, 10);
                    repeat (len) send_item(any_pop(), $urandom());
                end
                7:
                    send_item($urandom_range(0, 1) ? FUNC_DUMP_BWD : FUNC_DUMP_FWD, $urandom());
                8:
                    send_item(FUNC_W'($urandom_range(0, 7)), $urandom());
                default:
                begin
                    send_item(any_push(), $urandom());
                    send_item(any_pop(), $urandom());
                end
            endcase
        end
    endtask

    initial
    begin
        repeat (2) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed: empty cases, value extremes, both ends, reserved codes
        send_item(FUNC_POP_FRONT,  32'h1234_5678);
        send_item(FUNC_POP_BACK,   32'h0);
        send_item(FUNC_DUMP_FWD,   32'hffff_ffff);
        send_item(FUNC_DUMP_BWD,   32'h0);
        send_item(FUNC_PUSH_FRONT, 32'h7fff_ffff);
        send_item(FUNC_PUSH_BACK,  32'h8000_0000);
        send_item(FUNC_PUSH_FRONT, 32'h0000_0000);
        send_item(FUNC_PUSH_BACK,  32'hffff_ffff);
        send_item(FUNC_DUMP_FWD,   32'h0);
        send_item(FUNC_DUMP_BWD,   32'h0);
        send_item(FUNC_RSVD_A,     32'hffff_ffff);
        send_item(FUNC_RSVD_B,     32'h5555_5555);
        send_item(FUNC_POP_FRONT,  32'h0);
        send_item(FUNC_POP_BACK,   32'h0);
        send_item(FUNC_POP_BACK,   32'h0);
        send_item(FUNC_POP_FRONT,  32'h0);
        send_item(FUNC_POP_FRONT,  32'h0);
        send_item(FUNC_PUSH_BACK,  32'haaaa_aaaa);
        send_item(FUNC_POP_FRONT,  32'h0);
        send_item(FUNC_PUSH_FRONT, 32'h5555_5555);
        send_item(FUNC_DUMP_FWD,   32'h0);
        send_item(FUNC_POP_BACK,   32'h0);

        // Sender gaps light, receiver stalls heavy; fill past full
        send_idle_pct = 29;
        recv_idle_pct = 69;
        repeat (70) send_item(any_push(), $urandom());
        send_item(FUNC_DUMP_FWD, $urandom());
        send_item(FUNC_DUMP_BWD, $urandom());
        random_ops(12);

        // Roles swapped; drain past empty
        send_idle_pct = 69;
        recv_idle_pct = 29;
        repeat (70) send_item(any_pop(), $urandom());
        random_ops(10);

        // No idling at all
        send_idle_pct = 0;
        recv_idle_pct = 0;
        random_ops(25);
        s_axis_tvalid <= 1'b0;

        // Drain, then allow stray late results to show up
        while (pending != 0)
            @(negedge clk);
        repeat (16) @(negedge clk);

        if (fail_count == 0)
            $display("tb: done, clean");
        else
            $display("tb: done, errors");
        $finish;
    end

    // Watchdog
    initial
    begin
        #2_000_000;
        $display("tb: done, errors");
        $finish;
    end

endmodule
